### design/soft_timer_bank_unit_assert.svh
// ---------------------------------------------------------------------------
// soft_timer_bank_unit_assert.svh
// Assertion macros used by the timer bank checker.
// ---------------------------------------------------------------------------
`ifndef SOFT_TIMER_BANK_UNIT_ASSERT_SVH
`define SOFT_TIMER_BANK_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define STB_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer bank check failed");

// Next-cycle implication, disabled while reset is high.
`define STB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer bank check failed");

`endif

### design/stb_pkg.sv
// ---------------------------------------------------------------------------
// stb_pkg
// Sizes, codes and shared types of the soft timer bank.
// ---------------------------------------------------------------------------
`default_nettype none

package stb_pkg;

   // Bank size and derived widths
   localparam int NUM_TIMERS = 16;
   localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int PTR_W      = $clog2(NUM_TIMERS + 1);

   // Field widths
   localparam int FUNC_W  = 2;
   localparam int INDEX_W = 8;
   localparam int LIMIT_W = 16;
   localparam int COUNT_W = 16;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_START  = 2'd0,
      FUNC_CANCEL = 2'd1,
      FUNC_QUERY  = 2'd2,
      FUNC_TICK   = 2'd3
   } func_type;

   typedef logic [IDX_W-1:0] addr_type;

   // One timer entry as held in the memory
   typedef struct packed {
      logic               enabled;
      logic               expired;
      logic [COUNT_W-1:0] count;
      logic [LIMIT_W-1:0] limit;
   } entry_type;

   // Memory access from the sequencer
   typedef struct packed {
      logic      wr_en;
      addr_type  wr_addr;
      entry_type wr_data;
      logic      rd_en;
      addr_type  rd_addr;
   } mem_req_type;

   // Finished result from the sequencer
   typedef struct packed {
      logic valid;
      logic expired;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CANCEL_WB,
      ST_QUERY_RD,
      ST_TICK,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

### design/stb_req_if.sv
// ---------------------------------------------------------------------------
// stb_req_if
// Request channel: operation beats into the timer bank.
// ---------------------------------------------------------------------------
`default_nettype none

interface stb_req_if;
   import stb_pkg::*;

   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [INDEX_W-1:0] timer_index;
   logic [LIMIT_W-1:0] limit;

   modport source (output valid, output func, output timer_index, output limit,
                   input ready);
   modport sink   (input valid, input func, input timer_index, input limit,
                   output ready);
endinterface

`default_nettype wire

### design/stb_rsp_if.sv
// ---------------------------------------------------------------------------
// stb_rsp_if
// Response channel: one result beat per request beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface stb_rsp_if;
   logic valid;
   logic ready;
   logic expired;

   modport source (output valid, output expired, input ready);
   modport sink   (input valid, input expired, output ready);
endinterface

`default_nettype wire

### design/soft_timer_bank_unit.sv
// ---------------------------------------------------------------------------
// soft_timer_bank_unit
// Bank of one-shot software timers kept in a single entry memory.
// ---------------------------------------------------------------------------
//   channel  dir  fields                          beat
//   req_if   in   func, timer_index, limit        one operation
//   rsp_if   out  expired                         one result per operation
//
// A tick walks the entry memory one entry per cycle through its single
// read and single write port. Operations run one at a time.
// Reset is synchronous; the memory needs no clearing pass, unwritten
// entries read as zero. A stalled response sits in the output register
// while the next request is already taken.
// ---------------------------------------------------------------------------
`default_nettype none

module soft_timer_bank_unit (
   input wire logic clock,
   input wire logic reset,
   stb_req_if.sink  req_if,
   stb_rsp_if.source rsp_if
);
   import stb_pkg::*;

   mem_req_type mem_req;
   entry_type   rd_data;
   result_type  result;
   logic        out_free;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_expired_ff;

   stb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .mem_req  (mem_req),
      .rd_data  (rd_data),
      .result   (result),
      .out_free (out_free)
   );

   stb_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // Output register: load a finished result when the slot drains
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result.valid && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid && out_free) begin
         rsp_expired_ff <= result.expired;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.expired = rsp_expired_ff;

endmodule

`default_nettype wire

### design/stb_mem.sv
// ---------------------------------------------------------------------------
// stb_mem
// Timer entry memory: one write and one registered read port per cycle.
// Entries not yet written since reset read as all zero.
// ---------------------------------------------------------------------------
`default_nettype none

module stb_mem (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire stb_pkg::mem_req_type mem_req,
   output      stb_pkg::entry_type  rd_data
);
   import stb_pkg::*;

   entry_type              entry_mem [NUM_TIMERS];
   logic [NUM_TIMERS-1:0]  written_ff;
   entry_type              rd_data_ff;

   // Track which entries hold data since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (mem_req.wr_en) begin
         written_ff[mem_req.wr_addr] <= 1'b1;
      end
   end

   // Write port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         entry_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // Registered read port; unwritten entries read as reset value
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= written_ff[mem_req.rd_addr] ? entry_mem[mem_req.rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/stb_ctrl.sv
// ---------------------------------------------------------------------------
// stb_ctrl
// Operation sequencer: decodes request beats, runs read-modify-write
// passes over the entry memory and hands the result to the output stage.
// ---------------------------------------------------------------------------
`default_nettype none

module stb_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   stb_req_if.sink                   req_if,
   output      stb_pkg::mem_req_type mem_req,
   input  wire stb_pkg::entry_type   rd_data,
   output      stb_pkg::result_type  result,
   input  wire logic                 out_free
);
   import stb_pkg::*;

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   addr_type         wb_addr_ff, wb_addr_in;
   addr_type         addr_ff, addr_in;
   logic             hit_ff, hit_in;
   logic             res_exp_ff, res_exp_in;
   logic             in_range;
   addr_type         req_addr;
   logic [COUNT_W-1:0] count_inc;
   entry_type        tick_entry;

   assign in_range = {1'b0, req_if.timer_index} < (INDEX_W + 1)'(NUM_TIMERS);
   assign req_addr = req_if.timer_index[IDX_W-1:0];

   // Advance one entry on a tick
   assign count_inc = rd_data.count + 1'b1;
   always_comb begin
      tick_entry = rd_data;
      if (rd_data.enabled && !rd_data.expired) begin
         tick_entry.count   = count_inc;
         tick_entry.expired = (count_inc >= rd_data.limit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      wb_addr_ff <= wb_addr_in;
      addr_ff    <= addr_in;
      hit_ff     <= hit_in;
      res_exp_ff <= res_exp_in;
   end

   // Next state, memory accesses and handshake
   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      wb_addr_in   = wb_addr_ff;
      addr_in      = addr_ff;
      hit_in       = hit_ff;
      res_exp_in   = res_exp_ff;
      mem_req      = '0;
      result       = '0;
      req_if.ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            // take no beat while reset is held
            req_if.ready = !reset;
            if (req_if.valid) begin
               addr_in    = req_addr;
               hit_in     = in_range;
               res_exp_in = 1'b0;
               case (func_type'(req_if.func))
                  FUNC_START: begin
                     mem_req.wr_en           = in_range;
                     mem_req.wr_addr         = req_addr;
                     mem_req.wr_data.enabled = 1'b1;
                     mem_req.wr_data.expired = 1'b0;
                     mem_req.wr_data.count   = '0;
                     mem_req.wr_data.limit   = req_if.limit;
                     state_in                = ST_DONE;
                  end
                  FUNC_CANCEL: begin
                     mem_req.rd_en   = in_range;
                     mem_req.rd_addr = req_addr;
                     state_in        = ST_CANCEL_WB;
                  end
                  FUNC_QUERY: begin
                     mem_req.rd_en   = in_range;
                     mem_req.rd_addr = req_addr;
                     state_in        = ST_QUERY_RD;
                  end
                  FUNC_TICK: begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = '0;
                     wb_addr_in      = '0;
                     ptr_in          = PTR_W'(1);
                     state_in        = ST_TICK;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // Disable and clear expiry, keep count and limit
         ST_CANCEL_WB: begin
            mem_req.wr_en           = hit_ff;
            mem_req.wr_addr         = addr_ff;
            mem_req.wr_data         = rd_data;
            mem_req.wr_data.enabled = 1'b0;
            mem_req.wr_data.expired = 1'b0;
            state_in                = ST_DONE;
         end

         ST_QUERY_RD: begin
            res_exp_in = hit_ff & rd_data.expired;
            state_in   = ST_DONE;
         end

         // Write back the previous entry while reading the next one
         ST_TICK: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = wb_addr_ff;
            mem_req.wr_data = tick_entry;
            if (ptr_ff == PTR_W'(NUM_TIMERS)) begin
               state_in = ST_DONE;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = ptr_ff[IDX_W-1:0];
               wb_addr_in      = ptr_ff[IDX_W-1:0];
               ptr_in          = ptr_ff + 1'b1;
            end
         end

         // Hold the result until the output stage takes it
         ST_DONE: begin
            result.valid   = 1'b1;
            result.expired = res_exp_ff;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### design/stb_checker.sv
// ---------------------------------------------------------------------------
// stb_checker
// Port-level checks on the timer bank, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "soft_timer_bank_unit_assert.svh"

module stb_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [1:0] req_func,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_expired
);
   import stb_pkg::*;

   logic req_beat;
   logic tick_beat;

   assign req_beat  = req_valid && req_ready;
   assign tick_beat = req_beat && (req_func == FUNC_TICK);

   // A stalled response beat holds its value
   `STB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_expired))

   // One operation at a time: busy right after taking a beat
   `STB_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_beat, !req_ready)

   // A tick walks the memory: the request side stays busy after the tick beat
   `STB_ASSERT_NEXT(a_tick_busy, clock, reset, tick_beat, !req_ready ##1 !req_ready)

endmodule

bind soft_timer_bank_unit stb_checker u_stb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .req_func    (req_if.func),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_expired (rsp_if.expired)
);

`default_nettype wire
